FILE: rtl/core/masked_byte_signature_scanner_assert.svh
// Assertion macros used by the scanner's match stage (msbs_match).
// Both macros expect clk_i and rst_ni in the enclosing module.
`ifndef MASKED_BYTE_SIGNATURE_SCANNER_ASSERT_SVH
`define MASKED_BYTE_SIGNATURE_SCANNER_ASSERT_SVH

// Same-cycle implication.
`define MBSS_ASSERT_IMPLY(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MBSS_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/msbs_pkg.sv
`default_nettype none

package msbs_pkg;

  localparam int unsigned MAX_PATTERN_DEF     = 16;
  localparam int unsigned MAX_MATCH_LIMIT_DEF = 64;

  localparam int unsigned ADDR_W = 64;
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned PLEN_W = 5;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned CTX_W  = 8;
  localparam int unsigned CLEN_W = 10;
  localparam int unsigned PAT_W  = 128;

  typedef enum logic [2:0] {
    CFG_PATTERN_LOW    = 3'd0,
    CFG_PATTERN_HIGH   = 3'd1,
    CFG_MASK_LOW       = 3'd2,
    CFG_MASK_HIGH      = 3'd3,
    CFG_PATTERN_LENGTH = 3'd4,
    CFG_MAX_MATCHES    = 3'd5,
    CFG_CONTEXT_BEFORE = 3'd6,
    CFG_CONTEXT_AFTER  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic              region_first;
    logic [ADDR_W-1:0] start_addr;
    logic [LEN_W-1:0]  region_length;
    logic              new_scan;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  rlen;
    logic [LEN_W-1:0]  off;
    logic [PLEN_W-1:0] plen;
    logic [CNT_W-1:0]  number;
    logic              too_many;
  } hit_t;

endpackage

`default_nettype wire

FILE: rtl/core/msbs_match.sv
`default_nettype none
`include "masked_byte_signature_scanner_assert.svh"

module msbs_match #(
  parameter int unsigned MAX_PATTERN     = msbs_pkg::MAX_PATTERN_DEF,
  parameter int unsigned MAX_MATCH_LIMIT = msbs_pkg::MAX_MATCH_LIMIT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         item_valid_i,
  input  msbs_pkg::item_t              item_i,
  input  logic [msbs_pkg::PAT_W-1:0]   pattern_i,
  input  logic [msbs_pkg::PAT_W-1:0]   mask_i,
  input  logic [msbs_pkg::PLEN_W-1:0]  pattern_length_i,
  input  logic [msbs_pkg::CNT_W-1:0]   max_matches_i,
  output logic                         hit_valid_o,
  output msbs_pkg::hit_t               hit_o
);
  import msbs_pkg::*;

  localparam int unsigned D  = MAX_PATTERN;
  localparam int unsigned IW = (D > 1) ? $clog2(D) : 1;
  localparam int unsigned SW = $clog2(D + 1);

  logic [7:0]        win_q [D];
  logic [7:0]        win_d [D];
  logic [SW-1:0]     seen_q, seen_d;
  logic [LEN_W-1:0]  offset_q, offset_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              stopped_q, stopped_d;
  logic              hit_valid_q;
  hit_t              hit_q, hit_d;

  logic              step;
  logic [LEN_W-1:0]  pos;
  logic [CNT_W-1:0]  count_base;
  logic              stopped_base;
  logic [PLEN_W-1:0] plen;
  logic [CNT_W-1:0]  limit;
  logic              miss;
  logic              hit;
  logic [IW:0]       idx;

  assign step = en_i && item_valid_i;

  always_comb begin
    for (int i = 0; i < D - 1; i++) begin
      win_d[i] = item_i.region_first ? 8'd0 : win_q[i + 1];
    end
    win_d[D-1] = item_i.data_byte;

    seen_d = item_i.region_first ? '0 : seen_q;
    if (seen_d < SW'(D)) begin
      seen_d = seen_d + SW'(1);
    end

    pos      = item_i.region_first ? '0 : offset_q;
    offset_d = (pos == '1) ? pos : pos + LEN_W'(1);

    count_base   = item_i.new_scan ? '0 : count_q;
    stopped_base = item_i.new_scan ? 1'b0 : stopped_q;

    if (pattern_length_i == '0) begin
      plen = PLEN_W'(1);
    end else if (pattern_length_i > PLEN_W'(D)) begin
      plen = PLEN_W'(D);
    end else begin
      plen = pattern_length_i;
    end
    limit = (max_matches_i > CNT_W'(MAX_MATCH_LIMIT)) ? CNT_W'(MAX_MATCH_LIMIT)
                                                       : max_matches_i;

    miss = 1'b0;
    idx  = '0;
    for (int k = 0; k < D; k++) begin
      idx = (IW+1)'(D) - (IW+1)'(plen) + (IW+1)'(k);
      if ((PLEN_W'(k) < plen) &&
          (((win_d[idx[IW-1:0]] ^ pattern_i[8*k +: 8]) & mask_i[8*k +: 8]) != 8'd0)) begin
        miss = 1'b1;
      end
    end

    hit = !stopped_base && (pos < item_i.region_length) &&
          ((PLEN_W+1)'(seen_d) >= (PLEN_W+1)'(plen)) && !miss;

    count_d       = hit ? count_base + CNT_W'(1) : count_base;
    hit_d.base    = item_i.start_addr;
    hit_d.rlen    = item_i.region_length;
    hit_d.off     = pos + LEN_W'(1) - LEN_W'(plen);
    hit_d.plen    = plen;
    hit_d.number  = count_d;
    hit_d.too_many = count_d > limit;
    stopped_d     = stopped_base || (hit && hit_d.too_many);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < D; i++) begin
        win_q[i] <= 8'd0;
      end
      seen_q      <= '0;
      offset_q    <= '0;
      count_q     <= '0;
      stopped_q   <= 1'b0;
      hit_valid_q <= 1'b0;
    end else begin
      if (step) begin
        win_q     <= win_d;
        seen_q    <= seen_d;
        offset_q  <= offset_d;
        count_q   <= count_d;
        stopped_q <= stopped_d;
      end
      if (en_i) begin
        hit_valid_q <= step && hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q <= hit_d;
    end
  end

  assign hit_valid_o = hit_valid_q;
  assign hit_o       = hit_q;

  `MBSS_ASSERT_NEXT(a_stop_after_too_many, step && hit && hit_d.too_many, stopped_q, "too many matches did not stop the scan")
  `MBSS_ASSERT_IMPLY(a_no_hit_when_stopped, step && stopped_q && !item_i.new_scan, !hit, "match reported while the scan is stopped")
  `MBSS_ASSERT_IMPLY(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_MATCH_LIMIT + 1), "match count ran past the limit")

endmodule

`default_nettype wire

FILE: rtl/core/msbs_ctx.sv
`default_nettype none

module msbs_ctx (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         hit_valid_i,
  input  msbs_pkg::hit_t               hit_i,
  input  logic [msbs_pkg::CTX_W-1:0]   context_before_i,
  input  logic [msbs_pkg::CTX_W-1:0]   context_after_i,
  output logic                         out_valid_o,
  output logic [msbs_pkg::ADDR_W-1:0]  match_addr_o,
  output logic [msbs_pkg::ADDR_W-1:0]  ctx_addr_o,
  output logic [msbs_pkg::CLEN_W-1:0]  context_length_o,
  output logic [msbs_pkg::CNT_W-1:0]   match_number_o,
  output logic                         too_many_o
);
  import msbs_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] match_addr;
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  cstart;
    logic [LEN_W:0]    tail_start;
    logic [LEN_W-1:0]  rlen;
    logic [CNT_W-1:0]  number;
    logic              too_many;
  } stage_t;

  stage_t            st_q, st_d;
  logic              st_valid_q;
  logic              out_valid_q;
  logic [ADDR_W-1:0] match_addr_q;
  logic [ADDR_W-1:0] ctx_addr_q, ctx_addr_d;
  logic [CLEN_W-1:0] ctx_len_q, ctx_len_d;
  logic [CNT_W-1:0]  number_q;
  logic              too_many_q;
  logic [LEN_W+1:0]  end_sum;
  logic [CLEN_W-1:0] cend;

  always_comb begin
    st_d.match_addr  = hit_i.base + ADDR_W'(hit_i.off);
    st_d.base        = hit_i.base;
    st_d.cstart      = (hit_i.off > LEN_W'(context_before_i))
                       ? hit_i.off - LEN_W'(context_before_i) : '0;
    st_d.tail_start  = (LEN_W+1)'(hit_i.off) + (LEN_W+1)'(hit_i.plen);
    st_d.rlen        = hit_i.rlen;
    st_d.number      = hit_i.number;
    st_d.too_many    = hit_i.too_many;
  end

  always_comb begin
    ctx_addr_d = st_q.base + ADDR_W'(st_q.cstart);
    end_sum    = (LEN_W+2)'(st_q.tail_start) + (LEN_W+2)'(context_after_i);
    cend       = (end_sum > (LEN_W+2)'(st_q.rlen)) ? st_q.rlen[CLEN_W-1:0]
                                                   : end_sum[CLEN_W-1:0];
    ctx_len_d  = cend - st_q.cstart[CLEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      st_valid_q  <= hit_valid_i;
      out_valid_q <= st_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q         <= st_d;
      match_addr_q <= st_q.match_addr;
      ctx_addr_q   <= ctx_addr_d;
      ctx_len_q    <= ctx_len_d;
      number_q     <= st_q.number;
      too_many_q   <= st_q.too_many;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign match_addr_o     = match_addr_q;
  assign ctx_addr_o       = ctx_addr_q;
  assign context_length_o = ctx_len_q;
  assign match_number_o   = number_q;
  assign too_many_o       = too_many_q;

endmodule

`default_nettype wire

FILE: rtl/core/masked_byte_signature_scanner.sv
// Masked byte signature scanner. Memory bytes arrive one per request on the slave stream and
// are matched against a pattern of up to sixteen bytes under a per-byte mask; every match
// yields one request on the master stream with the match address, the context window clipped
// to the region, the running match number and the too-many flag. Once a match sets the
// too-many flag the scan stays silent until a request with new_scan set. One byte is taken
// in every cycle while the master stream does not stall; a result passes the input register,
// the compare register and two context registers, and the rate is set by the window update
// and parallel compare, which are combinational. While a result waits on the master stream
// the whole pipeline holds and the slave stream is stalled. Configuration is to be written
// only while the stream is idle; the block itself does not enforce this.
`default_nettype none

module masked_byte_signature_scanner #(
  parameter int unsigned MAX_PATTERN     = msbs_pkg::MAX_PATTERN_DEF,
  parameter int unsigned MAX_MATCH_LIMIT = msbs_pkg::MAX_MATCH_LIMIT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Slave stream.
  input  logic         s_tvalid,
  output logic         s_tready,
  // data_byte [7:0], region base address [71:8], region_length [103:72].
  input  logic [103:0] s_tdata,
  // region_first [0], new_scan [1].
  input  logic [1:0]   s_tuser,
  // Master stream.
  output logic         m_tvalid,
  input  logic         m_tready,
  // match address [63:0], context start address [127:64], context_length [137:128],
  // match_number [144:138], zero [151:145].
  output logic [151:0] m_tdata,
  // too_many [0].
  output logic         m_tuser,
  // Configuration writes.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i
);
  import msbs_pkg::*;

  logic [63:0]       pattern_low_q, pattern_high_q, mask_low_q, mask_high_q;
  logic [PLEN_W-1:0] pattern_length_q;
  logic [CNT_W-1:0]  max_matches_q;
  logic [CTX_W-1:0]  context_before_q, context_after_q;

  logic              en;
  logic              in_valid_q;
  item_t             in_q;
  logic              hit_valid;
  hit_t              hit;
  logic              out_valid;
  logic [ADDR_W-1:0] hit_addr;
  logic [ADDR_W-1:0] ctx_addr;
  logic [CLEN_W-1:0] context_length;
  logic [CNT_W-1:0]  match_number;
  logic              too_many;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_low_q    <= '0;
      pattern_high_q   <= '0;
      mask_low_q       <= '0;
      mask_high_q      <= '0;
      pattern_length_q <= PLEN_W'(1);
      max_matches_q    <= CNT_W'(64);
      context_before_q <= '0;
      context_after_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_PATTERN_LOW:    pattern_low_q    <= cfg_data_i;
        CFG_PATTERN_HIGH:   pattern_high_q   <= cfg_data_i;
        CFG_MASK_LOW:       mask_low_q       <= cfg_data_i;
        CFG_MASK_HIGH:      mask_high_q      <= cfg_data_i;
        CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data_i[PLEN_W-1:0];
        CFG_MAX_MATCHES:    max_matches_q    <= cfg_data_i[CNT_W-1:0];
        CFG_CONTEXT_BEFORE: context_before_q <= cfg_data_i[CTX_W-1:0];
        CFG_CONTEXT_AFTER:  context_after_q  <= cfg_data_i[CTX_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together whenever the output register can take a new value.
  assign en       = !out_valid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q.data_byte     <= s_tdata[7:0];
      in_q.start_addr    <= s_tdata[71:8];
      in_q.region_length <= s_tdata[103:72];
      in_q.region_first  <= s_tuser[0];
      in_q.new_scan      <= s_tuser[1];
    end
  end

  msbs_match #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_MATCH_LIMIT (MAX_MATCH_LIMIT)
  ) u_match (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (en),
    .item_valid_i     (in_valid_q),
    .item_i           (in_q),
    .pattern_i        ({pattern_high_q, pattern_low_q}),
    .mask_i           ({mask_high_q, mask_low_q}),
    .pattern_length_i (pattern_length_q),
    .max_matches_i    (max_matches_q),
    .hit_valid_o      (hit_valid),
    .hit_o            (hit)
  );

  msbs_ctx u_ctx (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (en),
    .hit_valid_i       (hit_valid),
    .hit_i             (hit),
    .context_before_i  (context_before_q),
    .context_after_i   (context_after_q),
    .out_valid_o       (out_valid),
    .match_addr_o      (hit_addr),
    .ctx_addr_o        (ctx_addr),
    .context_length_o  (context_length),
    .match_number_o    (match_number),
    .too_many_o        (too_many)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, match_number, context_length, ctx_addr, hit_addr};
  assign m_tuser  = too_many;

endmodule

`default_nettype wire

FILE: tb/sv/tb_masked_byte_signature_scanner.sv
module tb_masked_byte_signature_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  import msbs_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;

  typedef struct {
    logic [63:0] match_addr;
    logic [63:0] ctx_addr;
    logic [9:0]  ctx_len;
    logic [6:0]  number;
    logic        too_many;
  } hit_rec_t;

  class match_scoreboard;
    logic [127:0] pattern;
    logic [127:0] mask;
    logic [4:0]   plen_reg;
    logic [6:0]   limit_reg;
    logic [7:0]   ctx_before;
    logic [7:0]   ctx_after;
    logic [7:0]   window [16];
    int unsigned  bytes_seen;
    logic [31:0]  region_offset;
    int unsigned  match_count;
    bit           stopped;
    hit_rec_t     pending_hits [$];
    int unsigned  errors;

    function new();
      pattern = '0;
      mask = '0;
      plen_reg = 5'd1;
      limit_reg = 7'd64;
      ctx_before = '0;
      ctx_after = '0;
      foreach (window[i]) window[i] = '0;
      bytes_seen = 0;
      region_offset = '0;
      match_count = 0;
      stopped = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [63:0] v);
      case (idx)
        CFG_PATTERN_LOW:    pattern[63:0] = v;
        CFG_PATTERN_HIGH:   pattern[127:64] = v;
        CFG_MASK_LOW:       mask[63:0] = v;
        CFG_MASK_HIGH:      mask[127:64] = v;
        CFG_PATTERN_LENGTH: plen_reg = v[4:0];
        CFG_MAX_MATCHES:    limit_reg = v[6:0];
        CFG_CONTEXT_BEFORE: ctx_before = v[7:0];
        CFG_CONTEXT_AFTER:  ctx_after = v[7:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [103:0] tdata, logic [1:0] tuser);
      logic [63:0] base;
      logic [63:0] rlen;
      logic [31:0] pos;
      logic [63:0] off;
      logic [63:0] cstart;
      logic [63:0] tail_start;
      logic [63:0] cend;
      logic [63:0] span;
      int unsigned plen;
      int unsigned limit;
      int unsigned k;
      hit_rec_t    h;
      base = tdata[71:8];
      rlen = {32'd0, tdata[103:72]};
      if (tuser[1]) begin
        match_count = 0;
        stopped = 1'b0;
      end
      if (tuser[0]) begin
        foreach (window[i]) window[i] = '0;
        bytes_seen = 0;
        region_offset = '0;
      end
      for (k = 0; k < 15; k++) window[k] = window[k + 1];
      window[15] = tdata[7:0];
      if (bytes_seen < 16) bytes_seen++;
      pos = region_offset;
      if (region_offset != '1) region_offset++;
      plen = 32'(plen_reg);
      if (plen == 0) plen = 1;
      if (plen > 16) plen = 16;
      limit = 32'(limit_reg);
      if (limit > 64) limit = 64;
      if (stopped || {32'd0, pos} >= rlen || bytes_seen < plen) return;
      for (k = 0; k < plen; k++) begin
        if ((window[16 - plen + k] & mask[8*k +: 8]) != (pattern[8*k +: 8] & mask[8*k +: 8]))
          return;
      end
      off = {32'd0, pos} + 64'd1 - 64'(plen);
      cstart = (off > {56'd0, ctx_before}) ? off - {56'd0, ctx_before} : 64'd0;
      tail_start = off + 64'(plen);
      cend = ({56'd0, ctx_after} > rlen - tail_start) ? rlen : tail_start + {56'd0, ctx_after};
      span = cend - cstart;
      match_count++;
      h.match_addr = base + off;
      h.ctx_addr = base + cstart;
      h.ctx_len = span[9:0];
      h.number = match_count[6:0];
      h.too_many = match_count > limit;
      if (h.too_many) stopped = 1'b1;
      pending_hits = {pending_hits, h};
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_hit(logic [151:0] d, logic u);
      hit_rec_t e;
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                 $time, d, u);
        errors++;
        return;
      end
      e = pending_hits.pop_front();
      compare_field("match address", e.match_addr, d[63:0]);
      compare_field("context address", e.ctx_addr, d[127:64]);
      compare_field("context_length", 64'(e.ctx_len), 64'(d[137:128]));
      compare_field("match_number", 64'(e.number), 64'(d[144:138]));
      compare_field("padding", 64'd0, 64'(d[151:145]));
      compare_field("too_many", 64'(e.too_many), 64'(u));
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_tvalid;
  logic         s_tready;
  logic [103:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [151:0] m_tdata;
  logic         m_tuser;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i;
  logic [63:0]  cfg_data_i;

  match_scoreboard sb = new();
  bit              calm = 1'b0;
  int unsigned     rx_hold_cycles = 0;
  int unsigned     quiet_cycles = 0;
  logic [127:0]    cur_pat;
  logic [127:0]    cur_msk;
  int unsigned     cur_len;

  masked_byte_signature_scanner u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver either holds off for a requested stretch or idles at random.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles != 0) begin
        m_tready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 16);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready) sb.check_hit(m_tdata, m_tuser);
      if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tuser);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_masked_byte_signature_scanner: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_byte(logic [7:0] data, bit first, logic [63:0] base, logic [31:0] rlen,
                           bit fresh);
    while (!calm && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {rlen, base, data};
    s_tuser <= {fresh, first};
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (sb.pending_hits.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic configure(logic [63:0] pl, logic [63:0] ph, logic [63:0] ml, logic [63:0] mh,
                           logic [4:0] plen, logic [6:0] maxm, logic [7:0] cb, logic [7:0] ca);
    logic [63:0] vals [8];
    cfg_reg_e    idx;
    vals[CFG_PATTERN_LOW] = pl;
    vals[CFG_PATTERN_HIGH] = ph;
    vals[CFG_MASK_LOW] = ml;
    vals[CFG_MASK_HIGH] = mh;
    vals[CFG_PATTERN_LENGTH] = 64'(plen);
    vals[CFG_MAX_MATCHES] = 64'(maxm);
    vals[CFG_CONTEXT_BEFORE] = 64'(cb);
    vals[CFG_CONTEXT_AFTER] = 64'(ca);
    idx = idx.first();
    repeat (idx.num()) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i <= vals[idx];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_reg(idx, vals[idx]);
      idx = idx.next();
    end
    cfg_valid_i <= 1'b0;
    cur_pat = {ph, pl};
    cur_msk = {mh, ml};
    cur_len = (plen == 5'd0) ? 1 : (plen > 5'd16) ? 16 : 32'(plen);
  endtask

  // One region: a well-formed run of bytes, seeded with copies of the signature and a little
  // noise on the region fields and marks.
  task automatic scan_region(int unsigned n);
    logic [63:0] base;
    logic [31:0] rlen;
    logic [63:0] bb;
    logic [31:0] rl;
    logic [7:0]  b;
    logic [7:0]  seeded [$];
    bit          fresh;
    bit          first;
    bit          fr;
    int unsigned i;
    int unsigned k;
    case ($urandom_range(0, 3))
      0: base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 64));
      1: base = 64'($urandom_range(0, 4096));
      default: base = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 5))
      0: rlen = $urandom_range(0, n);
      1: rlen = $urandom;
      2: rlen = n + $urandom_range(0, 300);
      3: rlen = 32'hFFFF_FFFF;
      default: rlen = n;
    endcase
    fresh = ($urandom_range(0, 2) == 0);
    for (i = 0; i < n; i++) begin
      if (seeded.size() == 0 && $urandom_range(0, 9) < 2) begin
        for (k = 0; k < cur_len; k++)
          seeded = {seeded, (cur_pat[8*k +: 8] & cur_msk[8*k +: 8]) |
                            (8'($urandom) & ~cur_msk[8*k +: 8])};
      end
      b = (seeded.size() != 0) ? seeded.pop_front() : 8'($urandom);
      if ($urandom_range(0, 29) == 0) b = 8'($urandom);
      first = (i == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 59) == 0);
      fr = (i == 0 && fresh) || ($urandom_range(0, 99) == 0);
      bb = ($urandom_range(0, 24) == 0) ? {$urandom, $urandom} : base;
      rl = ($urandom_range(0, 24) == 0) ? $urandom : rlen;
      send_byte(b, first, bb, rl, fr);
    end
  endtask

  task automatic random_phase(int unsigned nbytes);
    logic [127:0] pat;
    logic [127:0] msk;
    logic [4:0]   plen;
    logic [6:0]   maxm;
    logic [7:0]   cb;
    logic [7:0]   ca;
    int unsigned  sent;
    int unsigned  n;
    int unsigned  k;
    pat = {$urandom, $urandom, $urandom, $urandom};
    for (k = 0; k < 16; k++) begin
      case ($urandom_range(0, 3))
        0, 1: msk[8*k +: 8] = 8'hFF;
        2: msk[8*k +: 8] = 8'h00;
        default: msk[8*k +: 8] = 8'($urandom);
      endcase
    end
    plen = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 16));
    maxm = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, 64));
    cb = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
    ca = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
    wait_for_results();
    configure(pat[63:0], pat[127:64], msk[63:0], msk[127:64], plen, maxm, cb, ca);
    sent = 0;
    while (sent < nbytes) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 100) : $urandom_range(1, 40);
      scan_region(n);
      sent += n;
    end
  endtask

  initial begin
    logic [7:0]  sig [4];
    logic [63:0] edge_base;
    int unsigned r;
    int unsigned k;
    int unsigned p;
    rst_ni <= 1'b0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_PATTERN_LOW;
    cfg_data_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Four-byte signature in a region that wraps the address space, hitting the match
    // limit, staying silent once stopped, and running past the end of the region.
    sig = '{8'hFF, 8'h00, 8'h5A, 8'hA5};
    edge_base = 64'hFFFF_FFFF_FFFF_FFFE;
    configure({$urandom, 32'hA55A_00FF}, {$urandom, $urandom}, '1, '0, 5'd4, 7'd1, 8'hFF,
              8'hFF);
    for (r = 0; r < 4; r++) begin
      for (k = 0; k < 4; k++)
        send_byte(sig[k], r == 0 && k == 0, edge_base, 32'd10,
                  (r == 0 || r == 3) && k == 0);
    end
    for (k = 0; k < 4; k++) send_byte(sig[k], k == 0, 64'd0, 32'd4, 1'b0);
    send_byte(8'hFF, 1'b1, 64'd0, 32'd0, 1'b0);

    // Zero pattern length and a zero match limit.
    wait_for_results();
    configure('0, '0, '0, '0, 5'd0, 7'd0, 8'd0, 8'd0);
    for (k = 0; k < 3; k++) send_byte(8'($urandom), k == 0, 64'd100, 32'd3, k == 0);

    // Every byte matches: the count runs past the clamped limit of sixty-four.
    wait_for_results();
    configure(64'($urandom), 64'($urandom), '0, '0, 5'd1, 7'd127, 8'd0, 8'hFF);
    for (k = 0; k < 80; k++) send_byte(8'($urandom), k == 0, 64'h1000, 32'd80, k == 0);

    // Receiver holds off while the sender keeps offering matching bytes.
    wait_for_results();
    configure(64'($urandom), 64'($urandom), '0, '0, 5'd31, 7'd64, 8'hFF, 8'hFF);
    rx_hold_cycles = 300;
    for (r = 0; r < 4; r++) begin
      for (k = 0; k < 40; k++)
        send_byte(8'($urandom), k == 0, {$urandom, $urandom}, 32'd40, k == 0);
    end

    for (p = 0; p < 10; p++) begin
      calm = (p == 3);
      random_phase(100);
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    wait_for_results();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
      $display("tb_masked_byte_signature_scanner: PASS");
    end else begin
      $display("tb_masked_byte_signature_scanner: FAIL");
    end
    $finish;
  end

endmodule
